// ----- hdl/bsd_pkg.sv -----
// Shared types, constants and helpers for the byte state stepper with digests.
package bsd_pkg;

   localparam logic [5:0]  STATE_MASK = 6'h3F;
   localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME  = 32'd16777619;
   localparam logic [7:0]  DELTA_KEY  = 8'h02;
   localparam logic [7:0]  MIX_PRIOR  = 8'd17;
   localparam logic [7:0]  MIX_BYTE   = 8'd29;
   localparam logic [2:0]  MOD_BASE   = 3'd7;

   // Message bytes folded into the step digest: eight tick bytes, prior, new, byte, winner.
   localparam int MSG_BYTES = 12;
   localparam int MSG_WIDTH = MSG_BYTES * 8;
   // One cell per digest byte.
   localparam int NUM_CELLS = MSG_BYTES;
   // Header bytes left after the constant prefix: byte and new state.
   localparam int HDR_TAIL  = 2;

   typedef struct packed {
      logic [63:0]          tick_count;
      logic [5:0]           prior_state;
      logic [5:0]           new_state;
      logic [2:0]           winner;
      logic                 chirality;
      logic [2:0]           channel;
      logic [3:0]           slot;
      logic [6:0]           class_flags;
      logic [31:0]          step_hash;
      logic [31:0]          header_hash;
      logic [MSG_WIDTH-1:0] msg;
      logic [HDR_TAIL*8-1:0] hdr_msg;
      logic [1:0]           hdr_left;
   } item_type;

   function automatic logic [31:0] fnv_add(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] x;
      x = h ^ {24'b0, b};
      return x * FNV_PRIME;
   endfunction

   // Hash of the fixed header prefix 00 1B 1C 1D 1E 1F.
   function automatic logic [31:0] hdr_seed();
      logic [31:0] h;
      h = fnv_add(FNV_BASIS, 8'h00);
      h = fnv_add(h, 8'h1B);
      h = fnv_add(h, 8'h1C);
      h = fnv_add(h, 8'h1D);
      h = fnv_add(h, 8'h1E);
      h = fnv_add(h, 8'h1F);
      return h;
   endfunction

   localparam logic [31:0] HDR_SEED = hdr_seed();

   // Modulo seven of a byte: octal digits sum to the same residue since 8 is 1 mod 7.
   function automatic logic [2:0] mod7(input logic [7:0] x);
      logic [4:0] s1;
      logic [3:0] s2;
      s1 = {2'b0, x[2:0]} + {2'b0, x[5:3]} + {3'b0, x[7:6]};
      s2 = {1'b0, s1[2:0]} + {2'b0, s1[4:3]};
      if (s2 >= {1'b0, MOD_BASE}) begin
         s2 = s2 - {1'b0, MOD_BASE};
      end
      return s2[2:0];
   endfunction

endpackage

// ----- hdl/bsd_step.sv -----
// State step: holds tick and machine state and builds the item entering the hash chain.
module bsd_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic [7:0]       req_byte_in,
   output bsd_pkg::item_type step_item
);
   import bsd_pkg::*;

   logic [63:0] tick_ff, tick_in;
   logic [5:0]  state_ff, state_in;
   logic [7:0]  mixed, x, delta, byte_val;
   logic [2:0]  win;
   logic [5:0]  curr;
   logic [6:0]  flags;

   always_comb begin
      byte_val = req_byte_in;
      tick_in  = tick_ff + 64'd1;
      mixed = ({2'b0, state_ff} * MIX_PRIOR) ^ (byte_val * MIX_BYTE) ^ tick_in[7:0];
      win   = mod7(mixed);
      x     = {2'b0, state_ff} ^ byte_val;
      delta = {x[6:0], x[7]} ^ {x[4:0], x[7:5]} ^ {x[1:0], x[7:2]} ^ DELTA_KEY;
      curr  = (state_ff + byte_val[5:0] + {3'b0, win} + delta[5:0]) & STATE_MASK;
      state_in = curr;

      flags    = '0;
      flags[0] = (byte_val == 8'h1B);
      flags[1] = (byte_val >= 8'h1C) && (byte_val <= 8'h1F);
      flags[2] = (byte_val >= 8'h10) && (byte_val <= 8'h1F);
      flags[3] = (byte_val <= 8'h0F);
      flags[4] = (byte_val >= 8'h40);
      flags[5] = (byte_val >= 8'h80) && (byte_val <= 8'hBF);
      flags[6] = (byte_val >= 8'hC0);

      step_item.tick_count  = tick_in;
      step_item.prior_state = state_ff;
      step_item.new_state   = curr;
      step_item.winner      = win;
      step_item.chirality   = tick_in[0] ^ byte_val[0] ^ curr[0];
      step_item.channel     = curr[3:1];
      step_item.slot        = byte_val[3:0] ^ curr[3:0];
      step_item.class_flags = flags;
      step_item.step_hash   = FNV_BASIS;
      step_item.header_hash = HDR_SEED;
      // Bytes are consumed from the low end, one per cell.
      step_item.msg      = {5'b0, win, byte_val, 2'b0, curr, 2'b0, state_ff, tick_in};
      step_item.hdr_msg  = {2'b0, curr, byte_val};
      step_item.hdr_left = 2'(HDR_TAIL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff  <= '0;
         state_ff <= '0;
      end else if (req_valid && req_ready) begin
         tick_ff  <= tick_in;
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/bsd_cell.sv -----
// Hash cell: folds one byte into each digest in use and hands the item on.
module bsd_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  bsd_pkg::item_type in_item,
   output logic             out_valid,
   input  logic             out_ready,
   output bsd_pkg::item_type out_item
);
   import bsd_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      item_in           = in_item;
      item_in.step_hash = fnv_add(in_item.step_hash, in_item.msg[7:0]);
      item_in.msg       = in_item.msg >> 8;
      // The header lane only needs its last two bytes, so it stops after them.
      if (in_item.hdr_left != 2'd0) begin
         item_in.header_hash = fnv_add(in_item.header_hash, in_item.hdr_msg[7:0]);
         item_in.hdr_msg     = in_item.hdr_msg >> 8;
         item_in.hdr_left    = in_item.hdr_left - 2'd1;
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- hdl/byte_state_step_with_digest_unit.sv -----
// Byte state stepper: one state step followed by a chain of twelve FNV-1a hash cells.
// Registers: one per hash cell; the step is combinational, and an item passes the cell registers in order.
// Throughput: one beat per cycle while rsp_ready is high.
// Each cell holds one item and does one or two 32-bit multiplies.
// A stalled result backs up the chain cell by cell; empty cells keep taking beats.
// Reset clears the tick and machine state to zero and empties every cell.
module byte_state_step_with_digest_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_tick_count,
   output logic [5:0]  rsp_prior_state,
   output logic [5:0]  rsp_new_state,
   output logic [2:0]  rsp_winner,
   output logic        rsp_chirality,
   output logic [2:0]  rsp_channel,
   output logic [3:0]  rsp_slot,
   output logic [6:0]  rsp_class_flags,
   output logic [31:0] rsp_step_hash,
   output logic [31:0] rsp_header_hash
);
   import bsd_pkg::*;

   logic     cell_valid [0:NUM_CELLS];
   logic     cell_ready [0:NUM_CELLS];
   item_type cell_item  [0:NUM_CELLS];

   bsd_step u_step (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (cell_ready[0]),
      .req_byte_in (req_byte_in),
      .step_item   (cell_item[0])
   );

   assign cell_valid[0] = req_valid;
   assign req_ready     = cell_ready[0];

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      bsd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[g]),
         .in_ready  (cell_ready[g]),
         .in_item   (cell_item[g]),
         .out_valid (cell_valid[g+1]),
         .out_ready (cell_ready[g+1]),
         .out_item  (cell_item[g+1])
      );
   end

   assign cell_ready[NUM_CELLS] = rsp_ready;
   assign rsp_valid       = cell_valid[NUM_CELLS];
   assign rsp_tick_count  = cell_item[NUM_CELLS].tick_count;
   assign rsp_prior_state = cell_item[NUM_CELLS].prior_state;
   assign rsp_new_state   = cell_item[NUM_CELLS].new_state;
   assign rsp_winner      = cell_item[NUM_CELLS].winner;
   assign rsp_chirality   = cell_item[NUM_CELLS].chirality;
   assign rsp_channel     = cell_item[NUM_CELLS].channel;
   assign rsp_slot        = cell_item[NUM_CELLS].slot;
   assign rsp_class_flags = cell_item[NUM_CELLS].class_flags;
   assign rsp_step_hash   = cell_item[NUM_CELLS].step_hash;
   assign rsp_header_hash = cell_item[NUM_CELLS].header_hash;

endmodule
